/* src/i2cw_pkg.sv */
// Shared types and constants for the I2C master write engine.
package i2cw_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DEV_ADDR   = 3'd0,
    REG_LONG_WAIT  = 3'd1,
    REG_SHORT_WAIT = 3'd2,
    REG_ACK_GAP    = 3'd3,
    REG_ERR_LIMIT  = 3'd4
  } reg_idx_e;

  localparam logic [7:0] DevAddrRst   = 8'd0;
  localparam logic [7:0] LongWaitRst  = 8'd40;
  localparam logic [7:0] ShortWaitRst = 8'd13;
  localparam logic [7:0] AckGapRst    = 8'd200;
  localparam logic [5:0] ErrLimitRst  = 6'd40;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_S_HIGH   = 4'd1,
    PH_S_SDALOW = 4'd2,
    PH_S_SCLLOW = 4'd3,
    PH_B_LOW    = 4'd4,
    PH_B_SETUP  = 4'd5,
    PH_B_HIGH   = 4'd6,
    PH_B_END    = 4'd7,
    PH_A_SETUP  = 4'd8,
    PH_A_HIGH   = 4'd9,
    PH_A_GAP    = 4'd10,
    PH_A_LOW    = 4'd11,
    PH_NEED     = 4'd12,
    PH_P_LOW    = 4'd13,
    PH_P_HIGH   = 4'd14,
    PH_P_END    = 4'd15
  } phase_e;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] long_wait;
    logic [7:0] short_wait;
    logic [7:0] ack_gap;
    logic [5:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       byte_taken;
    logic       busy_res;
    logic       ack_done;
    logic       no_ack;
    logic [5:0] error_count;
  } res_t;

endpackage

/* src/i2cw_if.sv */
// Valid/ready channel interfaces for tick beats and result beats.
interface i2cw_in_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       sda_in;

  modport source (output valid, byte_valid, data_byte, last_byte, sda_in, input ready);
  modport sink   (input valid, byte_valid, data_byte, last_byte, sda_in, output ready);
endinterface

interface i2cw_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       byte_taken;
  logic       busy_res;
  logic       ack_done;
  logic       no_ack;
  logic [5:0] error_count;

  modport source (output valid, scl_level, sda_level, sda_drive, byte_taken, busy_res,
                  ack_done, no_ack, error_count, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, byte_taken, busy_res,
                  ack_done, no_ack, error_count, output ready);
endinterface

/* src/i2cw_regs.sv */
// APB register file holding the engine's configuration.
module i2cw_regs
  import i2cw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= DevAddrRst;
      cfg_q.long_wait      <= LongWaitRst;
      cfg_q.short_wait     <= ShortWaitRst;
      cfg_q.ack_gap        <= AckGapRst;
      cfg_q.error_limit    <= ErrLimitRst;
    end else if (wr_en) begin
      case (idx)
        REG_DEV_ADDR:   cfg_q.device_address <= pwdata[7:0];
        REG_LONG_WAIT:  cfg_q.long_wait      <= pwdata[7:0];
        REG_SHORT_WAIT: cfg_q.short_wait     <= pwdata[7:0];
        REG_ACK_GAP:    cfg_q.ack_gap        <= pwdata[7:0];
        REG_ERR_LIMIT:  cfg_q.error_limit    <= pwdata[5:0];
        default: ;  // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DEV_ADDR:   prdata[7:0] = cfg_q.device_address;
      REG_LONG_WAIT:  prdata[7:0] = cfg_q.long_wait;
      REG_SHORT_WAIT: prdata[7:0] = cfg_q.short_wait;
      REG_ACK_GAP:    prdata[7:0] = cfg_q.ack_gap;
      REG_ERR_LIMIT:  prdata[5:0] = cfg_q.error_limit;
      default:        prdata = '0;
    endcase
  end

endmodule

/* src/i2c_master_write_engine.sv */
// Write-only I2C master: one input beat is one bus tick and yields one result beat of
// line levels and status. The engine takes a tick beat on every clock in which its
// result register is empty or is being emptied, so the sustained rate is one beat per
// cycle; a tick's result is registered and shown in the cycle after it is taken. The
// one-tick sequencer advances the bus phase and loads the result register in the same
// cycle. Bus timing is counted in ticks, not clocks: SCL low lasts short_wait ticks,
// data setup and SCL high last long_wait ticks, and the acknowledge is sampled at the
// end of the SCL high phase and again ack_gap ticks later (a count of zero behaves as
// one). Both samples high is a no-ack and bumps the error count, saturating at
// error_limit; an ack clears it. Configuration is written over the APB port and is
// picked up whenever a phase next loads its wait count.
module i2c_master_write_engine
  import i2cw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  i2cw_in_if.sink          in_i,
  i2cw_out_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  i2cw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --- Handshake: result register with a single slot --------------------------------
  logic step;    // tick beat accepted this cycle
  logic out_vld_q;
  res_t res_q;
  res_t res_d;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  // --- Sequencer state ---------------------------------------------------------------
  phase_e     phase_q,    phase_d;
  logic [2:0] bit_q,      bit_d;
  logic [7:0] wait_q,     wait_d;
  logic [7:0] shift_q,    shift_d;
  logic [7:0] held_q,     held_d;
  logic       last_q,     last_d;
  logic       first_q,    first_d;
  logic [5:0] cnt_q,      cnt_d;
  logic       addr_q,     addr_d;   // current ack belongs to the address byte

  logic       done;      // current timed phase ends on this tick
  logic       msb;
  logic       taken, ackd, nack;
  logic [6:0] cnt_inc;

  assign done    = (wait_q <= 8'd1);
  assign msb     = shift_q[7];
  assign cnt_inc = {1'b0, cnt_q} + 7'd1;

  // Next state for one tick
  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    wait_d  = done ? wait_q : wait_q - 8'd1;
    shift_d = shift_q;
    held_d  = held_q;
    last_d  = last_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    taken   = 1'b0;
    ackd    = 1'b0;
    nack    = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        wait_d = wait_q;
        if (in_i.byte_valid) begin
          taken   = 1'b1;
          held_d  = in_i.data_byte;
          last_d  = in_i.last_byte;
          addr_d  = 1'b1;
          phase_d = PH_S_HIGH;
          wait_d  = cfg.long_wait;
        end
      end
      PH_S_HIGH: if (done) begin
        phase_d = PH_S_SDALOW;
        wait_d  = cfg.long_wait;
      end
      PH_S_SDALOW: if (done) begin
        phase_d = PH_S_SCLLOW;
        wait_d  = cfg.short_wait;
      end
      PH_S_SCLLOW: if (done) begin
        shift_d = cfg.device_address;
        bit_d   = 3'd0;
        phase_d = PH_B_LOW;
        wait_d  = cfg.short_wait;
      end
      PH_B_LOW: if (done) begin
        if (bit_q != 3'd0) shift_d = {shift_q[6:0], 1'b0};
        phase_d = PH_B_SETUP;
        wait_d  = cfg.long_wait;
      end
      PH_B_SETUP: if (done) begin
        phase_d = PH_B_HIGH;
        wait_d  = cfg.long_wait;
      end
      PH_B_HIGH: if (done) begin
        if (bit_q == 3'd7) begin
          phase_d = PH_B_END;
        end else begin
          bit_d   = bit_q + 3'd1;
          phase_d = PH_B_LOW;
        end
        wait_d = cfg.short_wait;
      end
      PH_B_END: if (done) begin
        phase_d = PH_A_SETUP;
        wait_d  = cfg.long_wait;
      end
      PH_A_SETUP: if (done) begin
        phase_d = PH_A_HIGH;
        wait_d  = cfg.long_wait;
      end
      PH_A_HIGH: if (done) begin
        first_d = in_i.sda_in;
        phase_d = PH_A_GAP;
        wait_d  = cfg.ack_gap;
      end
      PH_A_GAP: if (done) begin
        ackd = 1'b1;
        nack = first_q & in_i.sda_in;
        if (nack) begin
          cnt_d = (cnt_inc < {1'b0, cfg.error_limit}) ? cnt_inc[5:0] : cfg.error_limit;
        end else begin
          cnt_d = 6'd0;
        end
        phase_d = PH_A_LOW;
        wait_d  = cfg.short_wait;
      end
      PH_A_LOW: if (done) begin
        if (addr_q) begin
          addr_d  = 1'b0;
          shift_d = held_q;
          bit_d   = 3'd0;
          phase_d = PH_B_LOW;
          wait_d  = cfg.short_wait;
        end else if (last_q) begin
          phase_d = PH_P_LOW;
          wait_d  = cfg.short_wait;
        end else begin
          phase_d = PH_NEED;
          wait_d  = 8'd0;
        end
      end
      PH_NEED: begin
        wait_d = wait_q;
        if (in_i.byte_valid) begin
          taken   = 1'b1;
          held_d  = in_i.data_byte;
          last_d  = in_i.last_byte;
          shift_d = in_i.data_byte;
          bit_d   = 3'd0;
          phase_d = PH_B_LOW;
          wait_d  = cfg.short_wait;
        end
      end
      PH_P_LOW: if (done) begin
        phase_d = PH_P_HIGH;
        wait_d  = cfg.long_wait;
      end
      PH_P_HIGH: if (done) begin
        phase_d = PH_P_END;
        wait_d  = cfg.long_wait;
      end
      PH_P_END: if (done) begin
        phase_d = PH_IDLE;
        wait_d  = 8'd0;
      end
      default: begin
        phase_d = PH_IDLE;
        wait_d  = 8'd0;
      end
    endcase
  end

  // Line levels for this tick, from the phase on entry
  always_comb begin
    res_d             = '0;
    res_d.scl_level   = 1'b1;
    res_d.sda_level   = 1'b1;
    res_d.sda_drive   = 1'b1;
    res_d.busy_res    = (phase_q != PH_IDLE) || taken;
    res_d.byte_taken  = taken;
    res_d.ack_done    = ackd;
    res_d.no_ack      = nack;
    res_d.error_count = cnt_d;
    unique case (phase_q)
      PH_S_SDALOW: res_d.sda_level = 1'b0;
      PH_S_SCLLOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = 1'b0;
      end
      PH_B_LOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = (bit_q == 3'd0) ? 1'b1 : msb;
      end
      PH_B_SETUP, PH_B_END: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = msb;
      end
      PH_B_HIGH: res_d.sda_level = msb;
      PH_A_SETUP, PH_A_LOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_drive = 1'b0;
      end
      PH_A_HIGH, PH_A_GAP: res_d.sda_drive = 1'b0;
      PH_NEED: res_d.scl_level = 1'b0;
      PH_P_LOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = 1'b0;
      end
      PH_P_HIGH: res_d.sda_level = 1'b0;
      default: ;  // idle, START high, STOP end: both lines high
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      wait_q  <= '0;
      shift_q <= '0;
      held_q  <= '0;
      last_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
      addr_q  <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      wait_q  <= wait_d;
      shift_q <= shift_d;
      held_q  <= held_d;
      last_q  <= last_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      addr_q  <= addr_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.scl_level   = res_q.scl_level;
  assign out_o.sda_level   = res_q.sda_level;
  assign out_o.sda_drive   = res_q.sda_drive;
  assign out_o.byte_taken  = res_q.byte_taken;
  assign out_o.busy_res    = res_q.busy_res;
  assign out_o.ack_done    = res_q.ack_done;
  assign out_o.no_ack      = res_q.no_ack;
  assign out_o.error_count = res_q.error_count;

endmodule

/* src/i2cw_checker.sv */
// Port-level checks on the result channel of the I2C write engine, and its bind.
module i2cw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       sda_level_i,
  input logic       sda_drive_i,
  input logic       byte_taken_i,
  input logic       busy_res_i,
  input logic       ack_done_i,
  input logic       no_ack_i,
  input logic [5:0] error_count_i
);

  logic beat;
  assign beat = out_valid_i && out_ready_i;

  // stalled result beat must stay valid with its error count unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(error_count_i))
    else $error("result beat dropped or changed while stalled");

  a_taken_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && byte_taken_i |-> busy_res_i)
    else $error("byte taken outside a transfer");

  a_nack_qual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && no_ack_i |-> ack_done_i)
    else $error("no-ack flagged without an acknowledge check");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && ack_done_i && !no_ack_i |-> error_count_i == 6'd0)
    else $error("ack did not clear the error count");

  a_release_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !sda_drive_i |-> sda_level_i)
    else $error("released SDA not reported high");

endmodule

bind i2c_master_write_engine i2cw_checker u_i2cw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .sda_level_i   (out_o.sda_level),
  .sda_drive_i   (out_o.sda_drive),
  .byte_taken_i  (out_o.byte_taken),
  .busy_res_i    (out_o.busy_res),
  .ack_done_i    (out_o.ack_done),
  .no_ack_i      (out_o.no_ack),
  .error_count_i (out_o.error_count)
);
